[rtl/core/bfsu_pkg.sv]
// Shared constants and types for the bytecode frame stack unit.
// No dependencies.
`timescale 1ns / 1ps
package bfsu_pkg;
   localparam int STACK_WORDS_DEF = 512;
   localparam int FRAME_LIMIT_DEF = 16;

   localparam logic [3:0] OP_PUSH_FRAME = 4'd0;
   localparam logic [3:0] OP_POP_FRAME  = 4'd1;
   localparam logic [3:0] OP_PUSH       = 4'd2;
   localparam logic [3:0] OP_POP        = 4'd3;
   localparam logic [3:0] OP_PEEK       = 4'd4;
   localparam logic [3:0] OP_READ_LOCAL = 4'd5;
   localparam logic [3:0] OP_WRITE_LOCAL = 4'd6;
   localparam logic [3:0] OP_DUP        = 4'd7;
   localparam logic [3:0] OP_SWAP       = 4'd8;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_OVERFLOW  = 3'd1;
   localparam logic [2:0] ST_UNDERFLOW = 3'd2;
   localparam logic [2:0] ST_SECURITY  = 3'd3;
   localparam logic [2:0] ST_RUNTIME   = 3'd4;
endpackage

[rtl/core/bytecode_frame_stack_unit.sv]
// Top level of the bytecode frame stack unit: word store, frame table and
// the sequencer that runs each operation over a shared address adder.
// Depends on bfsu_pkg.
`timescale 1ns / 1ps
// Simple ops and errors go check, response, finish; push frame, dup and swap add a
// write state that clears locals or moves words. One item at a time; the single-port
// word store sets the per-word cost. A new request is taken only in idle, after the
// previous result has been transferred.
// Reset: synchronous active high; clears frame count and control, sets
// protection on. Word store and frame table are undefined until written.
module bytecode_frame_stack_unit #(
   parameter int STACK_WORDS = bfsu_pkg::STACK_WORDS_DEF,
   parameter int FRAME_LIMIT = bfsu_pkg::FRAME_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op[3:0], value[19:4], arg_a[27:20], arg_b[35:28], arg_c[43:36], zero
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[15:0], status[18:16], no_frames[19], zero
   output logic [23:0] rsp_tdata
);
   localparam int AW = $clog2(STACK_WORDS);
   localparam int FW = $clog2(FRAME_LIMIT);
   localparam int CW = $clog2(FRAME_LIMIT + 1);
   localparam int SW = AW + 2; // signed working width for pointer math

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_WR    = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic prot_ff;
   logic [CW-1:0] count_ff, count_in;

   logic [15:0] mem [STACK_WORDS];
   logic [AW-1:0] fb_mem [FRAME_LIMIT];
   logic [AW-1:0] ob_mem [FRAME_LIMIT];
   logic [AW-1:0] tp_mem [FRAME_LIMIT];
   logic [AW-1:0] en_mem [FRAME_LIMIT];

   logic [3:0]  op_ff;
   logic [15:0] val_ff;
   logic [7:0]  a_ff, b_ff, c_ff;
   logic [AW-1:0] fp_ff, ob_ff, top_ff, end_ff;
   logic [9:0]  idx_ff, idx_in;     // step counter in loops
   logic [15:0] rd_ff, rd_in;
   logic [2:0]  st_ff, st_in;
   logic [15:0] tmp_ff [4];
   logic [15:0] q_ff;              // registered memory read

   // shared adder
   logic signed [SW+9:0] add_x, add_y, add_s;
   assign add_s = add_x + add_y;

   logic [FW-1:0] cur;
   assign cur = (count_ff == '0) ? '0 : FW'(count_ff - CW'(1));

   logic prot;
   assign prot = prot_ff;

   function automatic logic signed [SW+9:0] sx(input logic [AW-1:0] v);
      sx = $signed({{(SW+10-AW){1'b0}}, v});
   endfunction
   function automatic logic signed [SW+9:0] s8(input logic [7:0] v);
      s8 = $signed({{(SW+2){1'b0}}, v});
   endfunction

   logic [8:0] kk;
   assign kk = {1'b0, a_ff} + {1'b0, b_ff};

   // memory port
   logic mem_we;
   logic [AW-1:0] mem_addr;
   logic [15:0] mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_addr] <= mem_wd;
      q_ff <= mem[mem_addr];
   end

   // frame table update
   logic ft_we_new, ft_we_top;
   logic [FW-1:0] ft_new_idx;
   logic [AW-1:0] ft_top_val;
   logic [AW-1:0] nfp_ff, nfp_in;
   always_ff @(posedge clock) begin
      if (ft_we_top)
         tp_mem[cur] <= ft_top_val;
      if (ft_we_new) begin
         fb_mem[ft_new_idx] <= nfp_ff;
         ob_mem[ft_new_idx] <= AW'(nfp_ff + AW'(a_ff) + AW'(b_ff));
         tp_mem[ft_new_idx] <= AW'(nfp_ff + AW'(a_ff) + AW'(b_ff));
         en_mem[ft_new_idx] <= AW'(nfp_ff + AW'(a_ff) + AW'(b_ff) + AW'(c_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         prot_ff  <= 1'b1;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_wr_en)
            prot_ff <= csr_wr_data;
      end
   end

   logic tmp_we;
   logic [1:0] tmp_idx;
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      rd_ff  <= rd_in;
      st_ff  <= st_in;
      nfp_ff <= nfp_in;
      if (tmp_we)
         tmp_ff[tmp_idx] <= q_ff;
      if (req_tvalid && req_tready) begin
         op_ff  <= req_tdata[3:0];
         val_ff <= req_tdata[19:4];
         a_ff   <= req_tdata[27:20];
         b_ff   <= req_tdata[35:28];
         c_ff   <= req_tdata[43:36];
         fp_ff  <= fb_mem[cur];
         ob_ff  <= ob_mem[cur];
         top_ff <= tp_mem[cur];
         end_ff <= en_mem[cur];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_FIN);
   assign rsp_tdata  = {4'd0, (count_ff == '0), st_ff, rd_ff};

   // step index for dup; phase in idx_ff[0] (0 read, 1 write)
   logic [8:0] step;
   assign step = idx_ff[9:1];

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      rd_in = rd_ff;
      st_in = st_ff;
      nfp_in = nfp_ff;
      mem_we = 1'b0;
      mem_addr = top_ff;
      mem_wd = val_ff;
      ft_we_new = 1'b0;
      ft_we_top = 1'b0;
      ft_new_idx = FW'(count_ff);
      ft_top_val = top_ff;
      tmp_we = 1'b0;
      tmp_idx = '0;
      add_x = sx(top_ff);
      add_y = '0;
      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            rd_in = '0;
            st_in = bfsu_pkg::ST_OK;
            if (req_tvalid)
               state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = S_RESP;
            case (op_ff)
               bfsu_pkg::OP_PUSH_FRAME: begin
                  // first frame starts at word 0
                  add_x = (count_ff == '0) ? '0 : sx(top_ff);
                  add_y = (count_ff == '0) ? '0 : -s8(a_ff);
                  nfp_in = AW'(add_s);
                  if (count_ff >= CW'(FRAME_LIMIT))
                     st_in = bfsu_pkg::ST_OVERFLOW;
                  else if (count_ff != '0 && prot && add_s < sx(ob_ff))
                     st_in = bfsu_pkg::ST_UNDERFLOW;
                  else if (prot && (add_s + s8(a_ff) + s8(b_ff) + s8(c_ff))
                           > (SW+10)'(STACK_WORDS - 1))
                     st_in = bfsu_pkg::ST_OVERFLOW;
                  else
                     state_in = S_WR;
               end
               bfsu_pkg::OP_POP_FRAME: begin
                  if (count_ff == '0)
                     st_in = bfsu_pkg::ST_SECURITY;
                  else
                     count_in = count_ff - CW'(1);
               end
               bfsu_pkg::OP_PUSH: begin
                  if (count_ff == '0)
                     st_in = bfsu_pkg::ST_SECURITY;
                  else if (prot && top_ff >= end_ff)
                     st_in = bfsu_pkg::ST_OVERFLOW;
                  else begin
                     mem_we = 1'b1;
                     mem_addr = top_ff;
                     ft_we_top = 1'b1;
                     ft_top_val = AW'(top_ff + AW'(1));
                  end
               end
               bfsu_pkg::OP_POP: begin
                  if (count_ff == '0)
                     st_in = bfsu_pkg::ST_SECURITY;
                  else if (prot && top_ff <= ob_ff)
                     st_in = bfsu_pkg::ST_UNDERFLOW;
                  else begin
                     mem_addr = AW'(top_ff - AW'(1));
                     ft_we_top = 1'b1;
                     ft_top_val = AW'(top_ff - AW'(1));
                  end
               end
               bfsu_pkg::OP_PEEK: begin
                  add_y = -s8(b_ff);
                  mem_addr = AW'(add_s);
                  if (count_ff == '0)
                     st_in = bfsu_pkg::ST_SECURITY;
                  else if (b_ff == 8'd0)
                     st_in = bfsu_pkg::ST_RUNTIME;
                  else if (prot && add_s < sx(ob_ff))
                     st_in = bfsu_pkg::ST_UNDERFLOW;
               end
               bfsu_pkg::OP_READ_LOCAL, bfsu_pkg::OP_WRITE_LOCAL: begin
                  add_x = sx(fp_ff);
                  add_y = s8(a_ff);
                  mem_addr = AW'(add_s);
                  if (count_ff == '0)
                     st_in = bfsu_pkg::ST_SECURITY;
                  else if (prot && add_s >= sx(ob_ff))
                     st_in = bfsu_pkg::ST_SECURITY;
                  else if (op_ff == bfsu_pkg::OP_WRITE_LOCAL)
                     mem_we = 1'b1;
               end
               bfsu_pkg::OP_DUP: begin
                  add_y = $signed({{(SW+1){1'b0}}, kk});
                  if (count_ff == '0)
                     st_in = bfsu_pkg::ST_SECURITY;
                  else if (prot && add_s > sx(end_ff))
                     st_in = bfsu_pkg::ST_OVERFLOW;
                  else if (prot && (sx(top_ff) - $signed({{(SW+1){1'b0}}, kk}))
                           < sx(ob_ff))
                     st_in = bfsu_pkg::ST_UNDERFLOW;
                  else if (kk != 9'd0)
                     state_in = S_WR;
                  else
                     ft_we_top = 1'b1;
               end
               bfsu_pkg::OP_SWAP: begin
                  add_y = -$signed({{(SW+1){1'b0}}, kk});
                  if (count_ff == '0)
                     st_in = bfsu_pkg::ST_SECURITY;
                  else if (a_ff < 8'd1 || a_ff > 8'd2 || b_ff < 8'd1 || b_ff > 8'd2)
                     st_in = bfsu_pkg::ST_RUNTIME;
                  else if (prot && add_s < sx(ob_ff))
                     st_in = bfsu_pkg::ST_SECURITY;
                  else
                     state_in = S_WR;
               end
               default: st_in = bfsu_pkg::ST_RUNTIME;
            endcase
         end
         S_WR: begin
            case (op_ff)
               bfsu_pkg::OP_PUSH_FRAME: begin
                  mem_wd = 16'd0;
                  mem_addr = AW'(nfp_ff + AW'(a_ff) + AW'(idx_ff));
                  if (idx_ff[7:0] < b_ff && idx_ff[8] == 1'b0) begin
                     mem_we = 1'b1;
                     idx_in = idx_ff + 10'd1;
                  end else begin
                     ft_we_new = 1'b1;
                     ft_we_top = (count_ff != '0);
                     ft_top_val = nfp_ff;
                     count_in = count_ff + CW'(1);
                     state_in = S_RESP;
                  end
               end
               bfsu_pkg::OP_DUP: begin
                  // read top-k+i, then write top+i
                  if (!idx_ff[0])
                     mem_addr = AW'(top_ff - AW'(kk) + AW'(step));
                  else begin
                     mem_addr = AW'(top_ff + AW'(step));
                     mem_we = 1'b1;
                     mem_wd = q_ff;
                  end
                  idx_in = idx_ff + 10'd1;
                  if (idx_ff[0] && step == kk - 9'd1) begin
                     ft_we_top = 1'b1;
                     ft_top_val = AW'(top_ff + AW'(kk));
                     state_in = S_RESP;
                  end
               end
               default: begin
                  // swap: gather phase reads k words into tmp order, then writes
                  if (idx_ff[8] == 1'b0) begin
                     // step i: capture the previous read from q_ff at tmp[i-1], and read the next word
                     if ({1'b0, idx_ff[7:0]} < kk) begin
                        if (idx_ff[7:0] < a_ff)
                           mem_addr = AW'(top_ff - AW'(a_ff) + AW'(idx_ff[7:0]));
                        else
                           mem_addr = AW'(top_ff - AW'(kk) + AW'(idx_ff[7:0] - a_ff));
                     end
                     if (idx_ff[7:0] != 8'd0) begin
                        tmp_we = 1'b1;
                        tmp_idx = 2'(idx_ff[7:0] - 8'd1);
                     end
                     if ({1'b0, idx_ff[7:0]} == kk)
                        idx_in = 10'h100;
                     else
                        idx_in = idx_ff + 10'd1;
                  end else begin
                     mem_we = 1'b1;
                     mem_addr = AW'(top_ff - AW'(kk) + AW'(idx_ff[7:0]));
                     mem_wd = tmp_ff[idx_ff[1:0]];
                     idx_in = idx_ff + 10'd1;
                     if ({1'b0, idx_ff[7:0]} == kk - 9'd1)
                        state_in = S_RESP;
                  end
               end
            endcase
         end
         S_RESP: begin
            if (st_ff == bfsu_pkg::ST_OK &&
                (op_ff == bfsu_pkg::OP_POP || op_ff == bfsu_pkg::OP_PEEK ||
                 op_ff == bfsu_pkg::OP_READ_LOCAL))
               rd_in = q_ff;
            else
               rd_in = 16'd0;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (rsp_tready)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

[test/bfsu_checker.sv]
// Scoreboard for the bytecode frame stack unit: watches both stream channels and the
// control write port, predicts each result and compares it field by field.
// Depends on bfsu_pkg.
`timescale 1ns / 1ps
module bfsu_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   output int          fail_count,
   output int          pending,
   output int          results_seen
);
   localparam int NW = bfsu_pkg::STACK_WORDS_DEF;
   localparam int NF = bfsu_pkg::FRAME_LIMIT_DEF;

   typedef struct packed {
      logic        no_frames;
      logic [2:0]  status;
      logic [15:0] read_data;
   } stack_result_type;

   logic [15:0] words [NW];
   int fbase [NF];
   int obase [NF];
   int ftop  [NF];
   int fend  [NF];
   int depth;
   bit guard;
   stack_result_type expected_q[$];

   function automatic int wrap_addr(int x);
      return ((x % NW) + NW) % NW;
   endfunction

   function automatic stack_result_type run_stack_op(logic [47:0] d);
      stack_result_type r;
      logic [3:0]  op;
      logic [15:0] val;
      int a, b, c, cur, fp, ob, top, lim, nfp, k, i, base;
      logic [15:0] tmp [4];
      op  = d[3:0];
      val = d[19:4];
      a   = d[27:20];
      b   = d[35:28];
      c   = d[43:36];
      r   = '0;
      r.status = bfsu_pkg::ST_OK;
      cur = depth > 0 ? depth - 1 : 0;
      fp = 0; ob = 0; top = 0; lim = 0; nfp = 0;
      if (depth > 0 && depth <= NF) begin
         fp = fbase[cur]; ob = obase[cur]; top = ftop[cur]; lim = fend[cur];
      end
      if (op == bfsu_pkg::OP_PUSH_FRAME) begin
         if (depth >= NF) begin
            r.status = bfsu_pkg::ST_OVERFLOW;
         end else begin
            if (depth > 0) begin
               if (guard && top - a < ob) r.status = bfsu_pkg::ST_UNDERFLOW;
               else nfp = top - a;
            end
            if (r.status == bfsu_pkg::ST_OK && guard && nfp + a + b + c > NW - 1)
               r.status = bfsu_pkg::ST_OVERFLOW;
            if (r.status == bfsu_pkg::ST_OK) begin
               if (depth > 0) ftop[cur] = wrap_addr(nfp);
               fbase[depth] = wrap_addr(nfp);
               obase[depth] = wrap_addr(nfp + a + b);
               ftop[depth]  = obase[depth];
               fend[depth]  = wrap_addr(nfp + a + b + c);
               for (i = 0; i < b; i++) words[wrap_addr(nfp + a + i)] = '0;
               depth++;
            end
         end
      end else if (op > bfsu_pkg::OP_SWAP) begin
         r.status = bfsu_pkg::ST_RUNTIME;
      end else if (depth == 0) begin
         r.status = bfsu_pkg::ST_SECURITY;
      end else begin
         case (op)
            bfsu_pkg::OP_POP_FRAME: depth--;
            bfsu_pkg::OP_PUSH: begin
               if (guard && top >= lim) r.status = bfsu_pkg::ST_OVERFLOW;
               else begin
                  words[wrap_addr(top)] = val;
                  ftop[cur] = wrap_addr(top + 1);
               end
            end
            bfsu_pkg::OP_POP: begin
               if (guard && top <= ob) r.status = bfsu_pkg::ST_UNDERFLOW;
               else begin
                  ftop[cur] = wrap_addr(top - 1);
                  r.read_data = words[ftop[cur]];
               end
            end
            bfsu_pkg::OP_PEEK: begin
               if (b == 0) r.status = bfsu_pkg::ST_RUNTIME;
               else if (guard && top - b < ob) r.status = bfsu_pkg::ST_UNDERFLOW;
               else r.read_data = words[wrap_addr(top - b)];
            end
            bfsu_pkg::OP_READ_LOCAL, bfsu_pkg::OP_WRITE_LOCAL: begin
               if (guard && fp + a >= ob) r.status = bfsu_pkg::ST_SECURITY;
               else if (op == bfsu_pkg::OP_READ_LOCAL)
                  r.read_data = words[wrap_addr(fp + a)];
               else words[wrap_addr(fp + a)] = val;
            end
            bfsu_pkg::OP_DUP: begin
               k = a + b;
               if (guard && top + k > lim) r.status = bfsu_pkg::ST_OVERFLOW;
               else if (guard && top - k < ob) r.status = bfsu_pkg::ST_UNDERFLOW;
               else begin
                  for (i = 0; i < k; i++)
                     words[wrap_addr(top + i)] = words[wrap_addr(top - k + i)];
                  ftop[cur] = wrap_addr(top + k);
               end
            end
            default: begin
               if (a < 1 || a > 2 || b < 1 || b > 2) r.status = bfsu_pkg::ST_RUNTIME;
               else if (guard && top - (a + b) < ob) r.status = bfsu_pkg::ST_SECURITY;
               else begin
                  base = top - (a + b);
                  for (i = 0; i < a; i++) tmp[i] = words[wrap_addr(top - a + i)];
                  for (i = 0; i < b; i++) tmp[a + i] = words[wrap_addr(base + i)];
                  for (i = 0; i < a + b; i++) words[wrap_addr(base + i)] = tmp[i];
               end
            end
         endcase
      end
      if (r.status != bfsu_pkg::ST_OK) r.read_data = '0;
      r.no_frames = (depth == 0);
      return r;
   endfunction

   always @(posedge clock) begin
      stack_result_type got, want;
      if (reset) begin
         depth = 0;
         guard = 1'b1;
         expected_q.delete();
         fail_count = 0;
         results_seen = 0;
      end else begin
         if (csr_wr_en) guard = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[19:0];
            results_seen++;
            if (expected_q.size() == 0) begin
               $error("result transfer with nothing expected: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_q[0];
               expected_q.delete(0);
               if (got.read_data !== want.read_data) begin
                  $error("read_data expected %h actual %h", want.read_data, got.read_data);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.no_frames !== want.no_frames) begin
                  $error("no_frames expected %0d actual %0d", want.no_frames, got.no_frames);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) expected_q.push_back(run_stack_op(req_tdata));
      end
      pending = expected_q.size();
   end
endmodule

[test/tb.sv]
// Top of the bytecode frame stack unit testbench: clock, reset, control writes,
// directed and random operation streams with random back-pressure, verdict.
// Depends on bfsu_pkg, bytecode_frame_stack_unit and bfsu_checker.
`timescale 1ns / 1ps
module tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic        csr_wr_data = 0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   int          fail_count, pending, results_seen;
   int          sent = 0;
   int          cycles = 0;
   bit          hold_req = 0;
   bit          hold_done = 0;

   localparam int CYCLE_LIMIT = 10000000;

   bytecode_frame_stack_unit uut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   bfsu_checker chk (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL bytecode_frame_stack_unit");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver: random ready pattern, one long hold-off on request
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_req && !hold_done) begin
            rsp_tready <= 0;
            repeat (600) @(posedge clock);
            hold_done = 1;
         end
         rsp_tready <= 1;
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
         repeat (n) @(posedge clock);
         n = gap_len();
         if (n > 0) begin
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_op(logic [3:0] op, logic [15:0] val, logic [7:0] a,
                          logic [7:0] b, logic [7:0] c, bit no_gap = 0);
      int g;
      req_tdata  <= {4'b0, c, b, a, val, op};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      sent++;
      g = no_gap ? 0 : gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_guard(bit v);
      @(posedge clock);
      csr_wr_en   <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 0;
   endtask

   function automatic logic [7:0] pick_arg();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return 8'($urandom_range(0, 3));
      if (r < 95) return 8'($urandom_range(0, 15));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic random_op(bit burst);
      int r;
      logic [3:0] op;
      r = $urandom_range(0, 99);
      if (r < 25) op = bfsu_pkg::OP_PUSH;
      else if (r < 43) op = bfsu_pkg::OP_POP;
      else if (r < 51) op = bfsu_pkg::OP_PEEK;
      else if (r < 56) op = bfsu_pkg::OP_READ_LOCAL;
      else if (r < 61) op = bfsu_pkg::OP_WRITE_LOCAL;
      else if (r < 69) op = bfsu_pkg::OP_DUP;
      else if (r < 77) op = bfsu_pkg::OP_SWAP;
      else if (r < 88) op = bfsu_pkg::OP_PUSH_FRAME;
      else if (r < 97) op = bfsu_pkg::OP_POP_FRAME;
      else op = 4'($urandom_range(9, 15));
      if (op == bfsu_pkg::OP_SWAP && $urandom_range(0, 9) != 0)
         send_op(op, 16'($urandom), 8'($urandom_range(1, 2)), 8'($urandom_range(1, 2)),
                 pick_arg(), burst);
      else
         send_op(op, 16'($urandom), pick_arg(), pick_arg(),
                 $urandom_range(0, 3) == 0 ? 8'($urandom) : pick_arg(), burst);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;

      // fill every word with zeros through local clearing, unguarded to reach the last words
      set_guard(0);
      send_op(bfsu_pkg::OP_PUSH_FRAME, 0, 0, 255, 0);
      send_op(bfsu_pkg::OP_PUSH_FRAME, 0, 0, 255, 0);
      send_op(bfsu_pkg::OP_PUSH_FRAME, 0, 0, 2, 0);
      repeat (3) send_op(bfsu_pkg::OP_POP_FRAME, 0, 0, 0, 0);
      drain();
      set_guard(1);

      // directed corners
      send_op(bfsu_pkg::OP_POP_FRAME, 0, 0, 0, 0);
      send_op(bfsu_pkg::OP_PUSH, 16'h1234, 0, 0, 0);
      send_op(4'd15, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
      send_op(bfsu_pkg::OP_PUSH_FRAME, 0, 0, 200, 255);
      send_op(bfsu_pkg::OP_PUSH_FRAME, 0, 0, 2, 2);
      send_op(bfsu_pkg::OP_PEEK, 0, 0, 0, 0);
      send_op(bfsu_pkg::OP_POP, 0, 0, 0, 0);
      send_op(bfsu_pkg::OP_PUSH, 16'h7FFF, 0, 0, 0);
      send_op(bfsu_pkg::OP_PUSH, 16'h8000, 0, 0, 0);
      send_op(bfsu_pkg::OP_PUSH, 16'h5555, 0, 0, 0);
      send_op(bfsu_pkg::OP_PEEK, 0, 0, 1, 0);
      send_op(bfsu_pkg::OP_PEEK, 0, 0, 5, 0);
      send_op(bfsu_pkg::OP_WRITE_LOCAL, 16'hAAAA, 1, 0, 0);
      send_op(bfsu_pkg::OP_READ_LOCAL, 0, 1, 0, 0);
      send_op(bfsu_pkg::OP_READ_LOCAL, 0, 5, 0, 0);
      send_op(bfsu_pkg::OP_SWAP, 0, 1, 1, 0);
      send_op(bfsu_pkg::OP_SWAP, 0, 3, 1, 0);
      send_op(bfsu_pkg::OP_SWAP, 0, 2, 2, 0);
      send_op(bfsu_pkg::OP_DUP, 0, 1, 1, 0);
      send_op(bfsu_pkg::OP_PUSH_FRAME, 0, 5, 1, 1);
      send_op(bfsu_pkg::OP_POP, 0, 0, 0, 0);
      send_op(bfsu_pkg::OP_POP_FRAME, 0, 0, 0, 0);
      repeat (17) send_op(bfsu_pkg::OP_PUSH_FRAME, 0, 0, 0, 1, 1);
      repeat (17) send_op(bfsu_pkg::OP_POP_FRAME, 0, 0, 0, 0, 1);
      drain();

      // random phases, alternating guard setting
      for (int ph = 0; ph < 5; ph++) begin
         set_guard(ph % 2 == 0);
         for (int i = 0; i < 340; i++) begin
            if (ph == 2 && i == 100) hold_req = 1;
            random_op(ph == 2 && i >= 100 && i < 180);
         end
         drain();
      end

      repeat (50) @(posedge clock);
      $display("%0d items sent, %0d results checked over five guard phases", sent, results_seen);
      $display("covered all ops, bad codes, frame limits, wraparound and a long output stall");
      if (fail_count == 0)
         $display("PASS bytecode_frame_stack_unit");
      else
         $display("FAIL bytecode_frame_stack_unit");
      $finish;
   end
endmodule
